FILE: hw/rtl/idqc_pkg.sv
package idqc_pkg;

  localparam int unsigned OctetW   = 9;
  localparam int unsigned DotCntW  = 3;
  localparam int unsigned PrefixW  = 24;
  localparam int unsigned AddrW    = 32;
  localparam int unsigned ClassW   = 3;
  localparam int unsigned HostsW   = 24;

  localparam logic [7:0] CharZero = 8'd48;
  localparam logic [7:0] CharNine = 8'd57;
  localparam logic [7:0] CharDot  = 8'd46;

  localparam logic [OctetW-1:0]  OctetMax = 9'd255;
  localparam logic [OctetW-1:0]  OctetSat = 9'd256;
  localparam logic [DotCntW-1:0] DotsFull = 3'd3;

  // Upper bounds of the first octet per class
  localparam logic [7:0] ClassALast = 8'd127;
  localparam logic [7:0] ClassBLast = 8'd191;
  localparam logic [7:0] ClassCLast = 8'd223;
  localparam logic [7:0] ClassDLast = 8'd239;

  localparam logic [ClassW-1:0] ClassA = 3'd0;
  localparam logic [ClassW-1:0] ClassB = 3'd1;
  localparam logic [ClassW-1:0] ClassC = 3'd2;
  localparam logic [ClassW-1:0] ClassD = 3'd3;
  localparam logic [ClassW-1:0] ClassE = 3'd4;

  localparam logic [AddrW-1:0] MaskA = 32'hFF00_0000;
  localparam logic [AddrW-1:0] MaskB = 32'hFFFF_0000;
  localparam logic [AddrW-1:0] MaskC = 32'hFFFF_FF00;

  localparam logic [HostsW-1:0] HostsA = 24'd16777214;
  localparam logic [HostsW-1:0] HostsB = 24'd65534;
  localparam logic [HostsW-1:0] HostsC = 24'd254;

  localparam int unsigned OutDataW = 128;

  // Finished string handed from parser to classifier
  typedef struct packed {
    logic             addr_valid;
    logic [AddrW-1:0] address;
  } parse_rec_t;

endpackage

FILE: hw/rtl/idqc_parser.sv
module idqc_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            char_code,
  input  logic                  last_char,
  output logic                  rec_valid,
  input  logic                  rec_ready,
  output idqc_pkg::parse_rec_t  rec
);

  logic                           error_seen;
  logic [idqc_pkg::OctetW-1:0]    octet_value;
  logic [idqc_pkg::DotCntW-1:0]   dot_count;
  logic                           segment_has_digit;
  logic [idqc_pkg::PrefixW-1:0]   address_so_far;

  logic                           error_seen_next;
  logic [idqc_pkg::OctetW-1:0]    octet_value_next;
  logic [idqc_pkg::DotCntW-1:0]   dot_count_next;
  logic                           segment_has_digit_next;
  logic [idqc_pkg::PrefixW-1:0]   address_so_far_next;

  logic        accept;
  logic        is_digit;
  logic        is_dot;
  logic [3:0]  digit;
  logic [11:0] times_ten;
  logic        final_ok;

  assign in_ready = !rec_valid || rec_ready;
  assign accept   = in_valid && in_ready;

  assign is_digit  = (char_code >= idqc_pkg::CharZero) && (char_code <= idqc_pkg::CharNine);
  assign is_dot    = (char_code == idqc_pkg::CharDot);
  assign digit     = 4'(char_code - idqc_pkg::CharZero);
  // octet * 10 + digit as two shifts and two adds
  assign times_ten = {1'b0, octet_value[7:0], 3'b000}
                   + {3'b000, octet_value[7:0], 1'b0}
                   + {8'd0, digit};

  always_comb begin
    error_seen_next        = error_seen;
    octet_value_next       = octet_value;
    dot_count_next         = dot_count;
    segment_has_digit_next = segment_has_digit;
    address_so_far_next    = address_so_far;
    if (is_digit) begin
      if (octet_value < idqc_pkg::OctetSat) begin
        if (times_ten > 12'(idqc_pkg::OctetMax)) begin
          octet_value_next = idqc_pkg::OctetSat;
        end else begin
          octet_value_next = times_ten[idqc_pkg::OctetW-1:0];
        end
      end
      segment_has_digit_next = 1'b1;
    end else if (is_dot) begin
      if (!segment_has_digit || octet_value > idqc_pkg::OctetMax ||
          dot_count >= idqc_pkg::DotsFull) begin
        error_seen_next = 1'b1;
      end else begin
        address_so_far_next = {address_so_far[15:0], octet_value[7:0]};
        dot_count_next      = dot_count + 3'd1;
      end
      octet_value_next       = '0;
      segment_has_digit_next = 1'b0;
    end else begin
      error_seen_next = 1'b1;
    end
  end

  assign final_ok = !error_seen_next && (dot_count_next == idqc_pkg::DotsFull) &&
                    segment_has_digit_next && (octet_value_next <= idqc_pkg::OctetMax);

  always_ff @(posedge clk) begin
    if (rst) begin
      error_seen        <= 1'b0;
      octet_value       <= '0;
      dot_count         <= '0;
      segment_has_digit <= 1'b0;
      address_so_far    <= '0;
    end else if (accept) begin
      if (last_char) begin
        // string done: return to the idle state
        error_seen        <= 1'b0;
        octet_value       <= '0;
        dot_count         <= '0;
        segment_has_digit <= 1'b0;
        address_so_far    <= '0;
      end else begin
        error_seen        <= error_seen_next;
        octet_value       <= octet_value_next;
        dot_count         <= dot_count_next;
        segment_has_digit <= segment_has_digit_next;
        address_so_far    <= address_so_far_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (accept && last_char) begin
      rec_valid <= 1'b1;
    end else if (rec_ready) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_char) begin
      rec.addr_valid <= final_ok;
      rec.address    <= final_ok ? {address_so_far_next, octet_value_next[7:0]} : '0;
    end
  end

  // a fourth dot always poisons the string
  assert property (@(posedge clk) disable iff (rst)
    accept && !last_char && is_dot && (dot_count == idqc_pkg::DotsFull) |=> error_seen)
    else $error("fourth dot not flagged");

  assert property (@(posedge clk) disable iff (rst)
    accept && last_char |=> (dot_count == '0) && !error_seen && !segment_has_digit &&
                            (octet_value == '0))
    else $error("state not cleared after last character");

endmodule

FILE: hw/rtl/idqc_classifier.sv
module idqc_classifier (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 rec_valid,
  output logic                                 rec_ready,
  input  idqc_pkg::parse_rec_t                 rec,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_flag,
  output logic [idqc_pkg::OutDataW-1:0]        out_data
);

  logic [7:0]                   first_octet;
  logic [idqc_pkg::ClassW-1:0]  cls;
  logic [idqc_pkg::AddrW-1:0]   mask;
  logic [idqc_pkg::HostsW-1:0]  hosts;
  logic [idqc_pkg::AddrW-1:0]   bcast;

  assign rec_ready   = !out_valid || out_ready;
  assign first_octet = rec.address[31:24];

  always_comb begin
    if (!rec.addr_valid) begin
      cls   = idqc_pkg::ClassA;
      mask  = '0;
      hosts = '0;
    end else if (first_octet <= idqc_pkg::ClassALast) begin
      cls   = idqc_pkg::ClassA;
      mask  = idqc_pkg::MaskA;
      hosts = idqc_pkg::HostsA;
    end else if (first_octet <= idqc_pkg::ClassBLast) begin
      cls   = idqc_pkg::ClassB;
      mask  = idqc_pkg::MaskB;
      hosts = idqc_pkg::HostsB;
    end else if (first_octet <= idqc_pkg::ClassCLast) begin
      cls   = idqc_pkg::ClassC;
      mask  = idqc_pkg::MaskC;
      hosts = idqc_pkg::HostsC;
    end else if (first_octet <= idqc_pkg::ClassDLast) begin
      cls   = idqc_pkg::ClassD;
      mask  = '0;
      hosts = '0;
    end else begin
      cls   = idqc_pkg::ClassE;
      mask  = '0;
      hosts = '0;
    end
  end

  // invalid strings report all zeros
  assign bcast = rec.addr_valid ? (rec.address | ~mask) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_valid && rec_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      out_flag <= rec.addr_valid;
      out_data <= {5'd0, hosts, bcast, mask, cls, rec.address};
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_flag |-> (out_data == '0))
    else $error("invalid result carries nonzero fields");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flag && (out_data[66:35] == '0) |->
      (out_data[98:67] == '1) && (out_data[122:99] == '0) &&
      ((out_data[34:32] == idqc_pkg::ClassD) || (out_data[34:32] == idqc_pkg::ClassE)))
    else $error("zero mask without class D or E");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_flag |-> (out_data[98:67] == (out_data[31:0] | ~out_data[66:35])))
    else $error("broadcast does not match address and mask");

endmodule

FILE: hw/rtl/ipv4_dotted_quad_classifier.sv
// A result is registered first in the parser's record and then in the classifier's output register.
// One character per cycle while s_tready is high; parse state updates on each accepted character.
// A held result stalls the output register; one more finished string can wait in the
// parser, after which s_tready drops for every character until the output drains.
// Reset (rst, synchronous, active high) clears the parse state and both valid flags.
module ipv4_dotted_quad_classifier (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] char_code
  input  logic         s_tlast,   // last_char
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // [31:0] address, [34:32] address_class,
                                  // [66:35] subnet_mask, [98:67] broadcast_addr,
                                  // [122:99] max_hosts, [127:123] zero
  output logic         m_tuser    // addr_valid
);

  logic                 rec_valid;
  logic                 rec_ready;
  idqc_pkg::parse_rec_t rec;

  idqc_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .char_code (s_tdata),
    .last_char (s_tlast),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  idqc_classifier u_classifier (
    .clk       (clk),
    .rst       (rst),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_flag  (m_tuser),
    .out_data  (m_tdata)
  );

endmodule

FILE: bench/testbench.sv
module testbench;

  localparam int ItemTarget = 1400;
  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 10;
  localparam int HoldStart = 150;
  localparam int HoldCycles = 300;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_xfer_t;

  typedef struct packed {
    logic                        addr_valid;
    logic [idqc_pkg::AddrW-1:0]  address;
    logic [idqc_pkg::ClassW-1:0] address_class;
    logic [idqc_pkg::AddrW-1:0]  subnet_mask;
    logic [idqc_pkg::AddrW-1:0]  broadcast_addr;
    logic [idqc_pkg::HostsW-1:0] max_hosts;
  } quad_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [7:0]   s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         m_tuser;

  char_xfer_t   pending_chars[$];
  quad_result_t expected_quads[$];
  logic [7:0]   text_q[$];

  int failures = 0;
  int cycle_count = 0;
  int chars_accepted = 0;
  int total_chars = 1;
  int hold_left = 0;
  bit hold_done = 1'b0;

  // parser state as the block should hold it
  logic                         prs_bad = 1'b0;
  logic [idqc_pkg::OctetW-1:0]  prs_octet = '0;
  logic [idqc_pkg::DotCntW-1:0] prs_dots = '0;
  logic                         prs_digit = 1'b0;
  logic [idqc_pkg::PrefixW-1:0] prs_prefix = '0;

  ipv4_dotted_quad_classifier i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the parser by one character; classify on the last one.
  task automatic parse_char(input logic [7:0] ch, input logic is_last);
    int acc;
    quad_result_t res;
    logic [7:0] first;
    if (ch >= idqc_pkg::CharZero && ch <= idqc_pkg::CharNine) begin
      if (prs_octet < idqc_pkg::OctetSat) begin
        acc = int'(prs_octet) * 10 + int'(ch) - int'(idqc_pkg::CharZero);
        prs_octet = (acc > int'(idqc_pkg::OctetMax)) ? idqc_pkg::OctetSat
                                                     : acc[idqc_pkg::OctetW-1:0];
      end
      prs_digit = 1'b1;
    end else if (ch == idqc_pkg::CharDot) begin
      if (!prs_digit || prs_octet > idqc_pkg::OctetMax || prs_dots >= idqc_pkg::DotsFull) begin
        prs_bad = 1'b1;
      end else begin
        prs_prefix = {prs_prefix[15:0], prs_octet[7:0]};
        prs_dots = prs_dots + 3'd1;
      end
      prs_octet = '0;
      prs_digit = 1'b0;
    end else begin
      prs_bad = 1'b1;
    end
    if (!is_last) return;

    res = '0;
    res.addr_valid = !prs_bad && prs_dots == idqc_pkg::DotsFull && prs_digit &&
                     prs_octet <= idqc_pkg::OctetMax;
    if (res.addr_valid) begin
      res.address = {prs_prefix, prs_octet[7:0]};
      first = res.address[31:24];
      if (first <= idqc_pkg::ClassALast) begin
        res.address_class = idqc_pkg::ClassA;
        res.subnet_mask = idqc_pkg::MaskA;
        res.max_hosts = idqc_pkg::HostsA;
      end else if (first <= idqc_pkg::ClassBLast) begin
        res.address_class = idqc_pkg::ClassB;
        res.subnet_mask = idqc_pkg::MaskB;
        res.max_hosts = idqc_pkg::HostsB;
      end else if (first <= idqc_pkg::ClassCLast) begin
        res.address_class = idqc_pkg::ClassC;
        res.subnet_mask = idqc_pkg::MaskC;
        res.max_hosts = idqc_pkg::HostsC;
      end else if (first <= idqc_pkg::ClassDLast) begin
        res.address_class = idqc_pkg::ClassD;
      end else begin
        res.address_class = idqc_pkg::ClassE;
      end
      res.broadcast_addr = res.address | ~res.subnet_mask;
    end
    expected_quads.push_back(res);
    prs_bad = 1'b0;
    prs_octet = '0;
    prs_dots = '0;
    prs_digit = 1'b0;
    prs_prefix = '0;
  endtask

  function automatic int idle_pct(input bit receiver);
    int third;
    third = chars_accepted * 3 / total_chars;
    if (third == 0) return receiver ? 60 : 10;
    if (third == 1) return receiver ? 10 : 60;
    return 0;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      failures++;
    end
  endtask

  // Driver: predict on each accepted transfer, then offer the next character.
  always @(posedge clk) begin
    char_xfer_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        parse_char(s_tdata, s_tlast);
        chars_accepted <= chars_accepted + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
          nxt = pending_chars.pop_front();
          s_tdata <= nxt.ch;
          s_tlast <= nxt.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer, then decide the next ready.
  always @(posedge clk) begin
    quad_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_quads.size() == 0) begin
          $error("result transfer with no expectation pending");
          failures++;
        end else begin
          want = expected_quads.pop_front();
          check_field("addr_valid", 32'(want.addr_valid), 32'(m_tuser));
          check_field("address", want.address, m_tdata[31:0]);
          check_field("address_class", 32'(want.address_class), 32'(m_tdata[34:32]));
          check_field("subnet_mask", want.subnet_mask, m_tdata[66:35]);
          check_field("broadcast_addr", want.broadcast_addr, m_tdata[98:67]);
          check_field("max_hosts", 32'(want.max_hosts), 32'(m_tdata[122:99]));
          check_field("pad", 32'd0, 32'(m_tdata[127:123]));
        end
      end
      // hold off once for a long stretch so the block backs up to its input
      if (!hold_done && chars_accepted >= HoldStart) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        m_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= idle_pct(1'b1));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("** ipv4_dotted_quad_classifier: FAILED **");
      $finish;
    end
  end

  task automatic flush_string();
    for (int k = 0; k < text_q.size(); k++) begin
      pending_chars.push_back('{ch: text_q[k], last: (k == text_q.size() - 1)});
    end
    text_q.delete();
  endtask

  task automatic add_str(input string s);
    for (int k = 0; k < s.len(); k++) text_q.push_back(s[k]);
  endtask

  task automatic add_octet(input int value);
    if ($urandom_range(9) == 0) text_q.push_back(idqc_pkg::CharZero);
    add_str($sformatf("%0d", value));
  endtask

  function automatic int pick_octet();
    case ($urandom_range(7))
      0: return 0;
      1: return 255;
      default: return $urandom_range(255);
    endcase
  endfunction

  task automatic add_quad(input int bad_seg);
    for (int seg = 0; seg < 4; seg++) begin
      add_octet(seg == bad_seg ? $urandom_range(99999, 256) : pick_octet());
      if (seg < 3) text_q.push_back(idqc_pkg::CharDot);
    end
  endtask

  task automatic add_random_string();
    int nseg;
    case ($urandom_range(11))
      0: add_quad($urandom_range(3));
      1: begin
        nseg = $urandom_range(6, 1);
        for (int seg = 0; seg < nseg; seg++) begin
          if ($urandom_range(4) != 0) add_octet(pick_octet());
          if (seg < nseg - 1) text_q.push_back(idqc_pkg::CharDot);
        end
      end
      2: begin
        add_quad(-1);
        text_q.insert($urandom_range(text_q.size()), 8'($urandom_range(255)));
      end
      3: begin
        nseg = $urandom_range(8, 1);
        repeat (nseg) text_q.push_back(8'($urandom_range(255)));
      end
      default: add_quad(-1);
    endcase
    flush_string();
  endtask

  initial begin
    add_str("0.0.0.0");                 flush_string();
    add_str("255.255.255.255");         flush_string();
    add_str("127.255.255.255");         flush_string();
    add_str("128.0.0.1");               flush_string();
    add_str("191.255.0.0");             flush_string();
    add_str("192.168.1.1");             flush_string();
    add_str("223.255.255.254");         flush_string();
    add_str("224.0.0.1");               flush_string();
    add_str("239.255.255.255");         flush_string();
    add_str("240.0.0.0");               flush_string();
    add_str("1..2.3");                  flush_string();
    add_str("1.2.3.");                  flush_string();
    add_str("1.2.3.4x");                flush_string();
    add_str("1.2.3.4");
    text_q.push_back(8'h00);            flush_string();
    add_str("9.9.9.9");
    text_q.push_back(8'hFF);            flush_string();
    add_str("256.1.1.1");               flush_string();
    add_str("1.2.3.99999999");          flush_string();
    add_str("1.2.3.4.5");               flush_string();
    add_str("1.2.3");                   flush_string();
    add_str("010.001.000.099");         flush_string();
    add_str("7");                       flush_string();
    add_str(".");                       flush_string();
    add_str("1/2:3.4");                 flush_string();
    while (pending_chars.size() < ItemTarget) add_random_string();
    total_chars = pending_chars.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_chars.size() != 0 || s_tvalid || expected_quads.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (expected_quads.size() != 0) begin
      $error("%0d expected results never arrived", expected_quads.size());
      failures++;
    end
    if (failures == 0) begin
      $display("** ipv4_dotted_quad_classifier: PASSED **");
    end else begin
      $display("** ipv4_dotted_quad_classifier: FAILED **");
    end
    $finish;
  end

endmodule
